// ----- rtl/core/bckb_pkg.sv -----
// Package for the banked color-keyed blit: geometry constants, register
// indexes, result and request types. No dependencies.
package bckb_pkg;

    localparam int SCREEN_WIDTH = 640;
    localparam int BANK_BYTES   = 65536;
    localparam int BANK_SHIFT   = $clog2(BANK_BYTES);

    localparam int ADDR_W     = 20;
    localparam int ROW_W      = 11;
    localparam int X_W        = 10;
    localparam int Y_W        = 9;
    localparam int PIX_W      = 8;
    localparam int BANK_W     = 4;
    localparam int OFS_W      = 16;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int TDATA_W    = 32;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_X      = 3'd0,
        CFG_DEST_Y      = 3'd1,
        CFG_BLIT_WIDTH  = 3'd2,
        CFG_BLIT_HEIGHT = 3'd3,
        CFG_KEY_COLOR   = 3'd4,
        CFG_KEY_ENABLE  = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        KIND_BANK  = 1'b0,
        KIND_WRITE = 1'b1
    } t_kind;

    typedef struct packed {
        logic [X_W-1:0]   dest_x;
        logic [Y_W-1:0]   dest_y;
        logic [X_W-1:0]   blit_width;
        logic [Y_W-1:0]   blit_height;
        logic [PIX_W-1:0] key_color;
        logic             key_enable;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [X_W-1:0]   col;
        logic [ROW_W-1:0] srow;
    } t_item;

    typedef struct packed {
        t_kind             kind;
        logic [BANK_W-1:0] bank;
        logic [OFS_W-1:0]  offset;
        logic [PIX_W-1:0]  data;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ----- rtl/core/bckb_front.sv -----
// Input stage: sprite column/row counters and the input request register.
// Depends on bckb_pkg.
module bckb_front import bckb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_restart,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_take,
    output logic             o_valid,
    output t_item            o_item
);

    logic [X_W-1:0] r_col, n_col;
    logic [Y_W-1:0] r_row, n_row;
    logic           r_valid, n_valid;
    t_item          r_item;
    logic [X_W-1:0] eff_w;
    logic [Y_W-1:0] eff_h;
    logic           accept;
    logic [ROW_W-1:0] srow;

    assign eff_w   = (i_cfg.blit_width  == '0) ? X_W'(1) : i_cfg.blit_width;
    assign eff_h   = (i_cfg.blit_height == '0) ? Y_W'(1) : i_cfg.blit_height;
    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;
    assign srow    = ROW_W'(i_cfg.dest_y) + ROW_W'(eff_h) - ROW_W'(1) - ROW_W'(r_row);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_valid = accept ? 1'b1 : (i_take ? 1'b0 : r_valid);
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if ({1'b0, r_col} + (X_W+1)'(1) >= {1'b0, eff_w}) begin
                n_col = '0;
                if ({1'b0, r_row} + (Y_W+1)'(1) >= {1'b0, eff_h}) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + Y_W'(1);
                end
            end else begin
                n_col = r_col + X_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= '{pixel: i_pixel, col: r_col, srow: srow};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/core/bckb_emit.sv -----
// Address, bank tracking and color key: turns one stored request into up to
// two results for the output queue. Depends on bckb_pkg.
module bckb_emit import bckb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_room,
    output logic  o_take,
    output t_push o_push
);

    logic [BANK_W-1:0] r_cur_bank, n_cur_bank;
    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] addr;
    logic [BANK_W-1:0] bank;
    logic [OFS_W-1:0]  offset;
    logic              bank_chg;
    logic              wr;
    t_result           sel_res;
    t_result           wr_res;

    assign row_base = ADDR_W'(i_item.srow) * ADDR_W'(SCREEN_WIDTH);
    assign addr     = row_base + ADDR_W'(i_cfg.dest_x) + ADDR_W'(i_item.col);
    assign bank     = BANK_W'(addr >> BANK_SHIFT);
    assign offset   = OFS_W'(addr & ADDR_W'(BANK_BYTES - 1));
    assign bank_chg = bank != r_cur_bank;
    assign wr       = !(i_cfg.key_enable && i_item.pixel == i_cfg.key_color);
    assign o_take   = i_valid && i_room;

    always_comb begin
        sel_res = '{kind: KIND_BANK, bank: bank, offset: '0, data: '0, last: !wr};
        wr_res  = '{kind: KIND_WRITE, bank: bank, offset: offset, data: i_item.pixel,
                    last: 1'b1};
        o_push.cnt = '0;
        o_push.r0  = bank_chg ? sel_res : wr_res;
        o_push.r1  = wr_res;
        if (o_take) begin
            o_push.cnt = 2'(bank_chg) + 2'(wr);
        end
        n_cur_bank = (o_take && bank_chg) ? bank : r_cur_bank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_bank <= '0;
        end else begin
            r_cur_bank <= n_cur_bank;
        end
    end

endmodule

// ----- rtl/core/bckb_queue.sv -----
// Output queue of results; takes up to two results per cycle, hands out one.
// Depends on bckb_pkg.
module bckb_queue import bckb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_result            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, n_wp;
    logic [Q_PTR_W-1:0] r_rp, n_rp;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               pop;
    logic [Q_PTR_W-1:0] wp1;

    assign o_valid = r_cnt != '0;
    assign o_room  = r_cnt <= Q_CNT_W'(Q_DEPTH - 2);
    assign pop     = o_valid && i_ready;
    assign wp1     = r_wp + Q_PTR_W'(1);
    assign o_res   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp + Q_PTR_W'(i_push.cnt);
        n_rp  = r_rp + Q_PTR_W'(pop);
        n_cnt = r_cnt + Q_CNT_W'(i_push.cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp1] <= i_push.r1;
        end
    end

endmodule

// ----- rtl/core/banked_color_keyed_blit.sv -----
// Top level of the banked color-keyed blit: configuration registers and the
// input stage, emit stage and output queue. Depends on bckb_pkg and submodules.
//
// Usage: sprite pixel bytes enter on the s_ stream, one request per pixel, in
// buffer order (bottom screen row first). Results leave on the m_ stream:
// a bank select (tuser 0) when the 64 KiB bank changes, then a pixel write
// (tuser 1) unless the pixel matches the enabled color key; tlast marks the
// final result of each pixel. A result passes the input request register
// and then the output queue. Throughput is one pixel per cycle while the
// queue has room; bank selects share the single-result-per-cycle output port.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle;
// the user must ensure idle, as the block does not enforce it. Geometry
// writes restart the sprite at its first pixel. Reset restores register
// defaults (size 1x1, origin 0, keying off), clears the counters, the bank
// tracker and the queue. When the receiver stalls, up to four results wait
// in the queue; the stored request waits when fewer than two entries are free.
module banked_color_keyed_blit import bckb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // [3:0] bank, [19:4] offset, [27:20] data
    output logic                  m_tuser,   // [0] kind
    output logic                  m_tlast
);

    t_cfg    r_cfg;
    logic    restart;
    logic    take;
    logic    item_valid;
    t_item   item;
    t_push   push;
    logic    room;
    t_result res;

    always_comb begin
        restart = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                CFG_DEST_X, CFG_DEST_Y, CFG_BLIT_WIDTH, CFG_BLIT_HEIGHT: restart = 1'b1;
                default: restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{dest_x: '0, dest_y: '0, blit_width: X_W'(1), blit_height: Y_W'(1),
                       key_color: '0, key_enable: 1'b0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEST_X:      r_cfg.dest_x      <= X_W'(i_cfg_data);
                CFG_DEST_Y:      r_cfg.dest_y      <= Y_W'(i_cfg_data);
                CFG_BLIT_WIDTH:  r_cfg.blit_width  <= X_W'(i_cfg_data);
                CFG_BLIT_HEIGHT: r_cfg.blit_height <= Y_W'(i_cfg_data);
                CFG_KEY_COLOR:   r_cfg.key_color   <= PIX_W'(i_cfg_data);
                CFG_KEY_ENABLE:  r_cfg.key_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bckb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (restart),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_pixel   (s_tdata),
        .i_take    (take),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    bckb_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (item_valid),
        .i_item  (item),
        .i_room  (room),
        .o_take  (take),
        .o_push  (push)
    );

    bckb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_res   (res)
    );

    assign m_tdata = {(TDATA_W - BANK_W - OFS_W - PIX_W)'(0), res.data, res.offset, res.bank};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

// ----- verif/tb_banked_color_keyed_blit.sv -----
// Self-checking testbench for banked_color_keyed_blit: directed stimulus table, then random
// sprite phases, with results checked against an in-bench model of the bank/key rules.
// Depends on bckb_pkg and the banked_color_keyed_blit RTL.
module tb_banked_color_keyed_blit;
    timeunit 1ns;
    timeprecision 1ps;

    import bckb_pkg::*;

    localparam int RST_CYCLES     = 6;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_CYCLES    = 200;
    localparam int STALL_LIMIT    = 1000;
    localparam int RANDOM_ITEMS   = 480;
    localparam int MAX_REPORTS    = 40;
    localparam int PRESSURE_PHASE = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 3'd7;

    localparam t_result NO_RESULT = '0;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MOSTLY,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [PIX_W-1:0]      pix;
        logic                  fixed;
        logic [1:0]            nres;
        t_result               r0;
        t_result               r1;
    } t_sprite_step;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata    = '0;
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    logic hold_req = 1'b0;
    int   burst_left = 0;
    int   mismatches = 0;

    t_result fb_ops_due[$];

    logic [X_W-1:0]    cfg_dest_x    = '0;
    logic [Y_W-1:0]    cfg_dest_y    = '0;
    logic [X_W-1:0]    cfg_width     = 10'd1;
    logic [Y_W-1:0]    cfg_height    = 9'd1;
    logic [PIX_W-1:0]  cfg_key_color = '0;
    logic              cfg_key_on    = 1'b0;
    int unsigned       col_pos       = 0;
    int unsigned       row_pos       = 0;
    logic [BANK_W-1:0] bank_now      = '0;

    banked_color_keyed_blit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_result bank_sel(input logic [BANK_W-1:0] bank, input logic last);
        t_result r;
        r = '0;
        r.kind = KIND_BANK;
        r.bank = bank;
        r.last = last;
        return r;
    endfunction

    function automatic t_result px_write(input logic [BANK_W-1:0] bank,
                                         input logic [OFS_W-1:0] ofs,
                                         input logic [PIX_W-1:0] data);
        t_result r;
        r = '0;
        r.kind   = KIND_WRITE;
        r.bank   = bank;
        r.offset = ofs;
        r.data   = data;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic t_sprite_step reg_row(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] val);
        t_sprite_step s;
        s = '0;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.val    = val;
        return s;
    endfunction

    function automatic t_sprite_step pix_row(input logic [PIX_W-1:0] pix);
        t_sprite_step s;
        s = '0;
        s.pix = pix;
        return s;
    endfunction

    function automatic t_sprite_step pix_fixed(input logic [PIX_W-1:0] pix,
                                               input logic [1:0] nres,
                                               input t_result r0, input t_result r1);
        t_sprite_step s;
        s = pix_row(pix);
        s.fixed = 1'b1;
        s.nres  = nres;
        s.r0    = r0;
        s.r1    = r1;
        return s;
    endfunction

    // Place one pixel, emit bank select and/or write, advance the sprite counters.
    function automatic int blit_step(input logic [PIX_W-1:0] pix,
                                     output t_result first, output t_result second);
        int unsigned       w;
        int unsigned       h;
        int unsigned       scr_row;
        int unsigned       addr;
        logic [BANK_W-1:0] bank;
        logic [OFS_W-1:0]  ofs;
        logic              keep;
        int                n;
        w       = (cfg_width == 0) ? 1 : cfg_width;
        h       = (cfg_height == 0) ? 1 : cfg_height;
        scr_row = cfg_dest_y + (h - 1 - row_pos);
        addr    = scr_row * SCREEN_WIDTH + cfg_dest_x + col_pos;
        bank    = BANK_W'(addr / BANK_BYTES);
        ofs     = OFS_W'(addr % BANK_BYTES);
        keep    = !(cfg_key_on && pix == cfg_key_color);
        n       = 0;
        first   = NO_RESULT;
        second  = NO_RESULT;
        if (bank != bank_now) begin
            first    = bank_sel(bank, !keep);
            n        = 1;
            bank_now = bank;
        end
        if (keep) begin
            if (n == 0) begin
                first = px_write(bank, ofs, pix);
            end else begin
                second = px_write(bank, ofs, pix);
            end
            n++;
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        return n;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns  mismatch: %s", $time, what);
        end
    endtask

    task automatic run_step(input t_sprite_step st);
        t_result a;
        t_result b;
        int      n;
        int      gap;
        if (st.is_cfg) begin
            s_tvalid <= 1'b0;
            while (fb_ops_due.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= st.idx;
            i_cfg_data <= st.val;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
            case (st.idx)
                CFG_DEST_X: begin
                    cfg_dest_x = st.val;
                    col_pos    = 0;
                    row_pos    = 0;
                end
                CFG_DEST_Y: begin
                    cfg_dest_y = st.val[Y_W-1:0];
                    col_pos    = 0;
                    row_pos    = 0;
                end
                CFG_BLIT_WIDTH: begin
                    cfg_width = st.val;
                    col_pos   = 0;
                    row_pos   = 0;
                end
                CFG_BLIT_HEIGHT: begin
                    cfg_height = st.val[Y_W-1:0];
                    col_pos    = 0;
                    row_pos    = 0;
                end
                CFG_KEY_COLOR:  cfg_key_color = st.val[PIX_W-1:0];
                CFG_KEY_ENABLE: cfg_key_on = st.val[0];
                default: ;
            endcase
        end else begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= st.pix;
            do @(posedge i_clk); while (s_tready !== 1'b1);
            burst_left--;
            n = blit_step(st.pix, a, b);
            if (st.fixed) begin
                n = st.nres;
                a = st.r0;
                b = st.r1;
            end
            if (n > 0) fb_ops_due.push_back(a);
            if (n > 1) fb_ops_due.push_back(b);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (fb_ops_due.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending: tdata %h tuser %b",
                                        m_tdata, m_tuser));
            end else begin
                want = fb_ops_due.pop_front();
                if (m_tuser !== want.kind)
                    note_mismatch($sformatf("kind got %b want %b", m_tuser, want.kind));
                if (m_tdata[3:0] !== want.bank)
                    note_mismatch($sformatf("bank got %h want %h", m_tdata[3:0], want.bank));
                if (m_tdata[19:4] !== want.offset)
                    note_mismatch($sformatf("offset got %h want %h", m_tdata[19:4],
                                            want.offset));
                if (m_tdata[27:20] !== want.data)
                    note_mismatch($sformatf("data got %h want %h", m_tdata[27:20], want.data));
                if (m_tlast !== want.last)
                    note_mismatch($sformatf("last got %b want %b", m_tlast, want.last));
            end
        end
    end

    initial begin : sink_side
        t_rx_mode    mode;
        int unsigned cyc;
        logic        held;
        mode = RX_OPEN;
        cyc  = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end
            if (cyc % 64 == 0) mode = t_rx_mode'($urandom_range(0, 3));
            case (mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_MOSTLY: m_tready <= (cyc % 4) != 3;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                default:   m_tready <= (cyc % 8) == 0;
            endcase
            cyc++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** banked_color_keyed_blit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        t_sprite_step plan[$];
        int unsigned  dx;
        int unsigned  dy;
        int unsigned  w;
        int unsigned  h;
        int unsigned  kbank;
        int unsigned  brow;
        int unsigned  bcol;
        int unsigned  shape;
        int unsigned  n_items;
        logic [9:0]   key_val;
        logic [9:0]   key_on_val;
        logic [7:0]   p;
        int           phase;
        int           random_sent;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(pix_fixed(8'h00, 2'd1, px_write(4'd0, 16'h0000, 8'h00), NO_RESULT));
        plan.push_back(pix_fixed(8'hFF, 2'd1, px_write(4'd0, 16'h0000, 8'hFF), NO_RESULT));
        plan.push_back(reg_row(CFG_DEST_X, 10'd639));
        plan.push_back(reg_row(CFG_DEST_Y, 10'd479));
        plan.push_back(pix_fixed(8'h5A, 2'd2, bank_sel(4'd4, 1'b0),
                                 px_write(4'd4, 16'hAFFF, 8'h5A)));
        plan.push_back(reg_row(CFG_KEY_COLOR, 10'h05A));
        plan.push_back(reg_row(CFG_KEY_ENABLE, 10'h001));
        plan.push_back(pix_fixed(8'h5A, 2'd0, NO_RESULT, NO_RESULT));
        plan.push_back(pix_fixed(8'hA5, 2'd1, px_write(4'd4, 16'hAFFF, 8'hA5), NO_RESULT));
        plan.push_back(reg_row(CFG_DEST_X, 10'd0));
        plan.push_back(reg_row(CFG_DEST_Y, 10'd0));
        plan.push_back(pix_fixed(8'h5A, 2'd1, bank_sel(4'd0, 1'b1), NO_RESULT));
        plan.push_back(reg_row(CFG_KEY_ENABLE, 10'h3FE));
        plan.push_back(pix_fixed(8'h5A, 2'd1, px_write(4'd0, 16'h0000, 8'h5A), NO_RESULT));
        plan.push_back(reg_row(CFG_IDX_SPARE, 10'h3FF));
        plan.push_back(pix_fixed(8'h01, 2'd1, px_write(4'd0, 16'h0000, 8'h01), NO_RESULT));
        plan.push_back(reg_row(CFG_DEST_X, 10'd1023));
        plan.push_back(reg_row(CFG_DEST_Y, 10'd511));
        plan.push_back(reg_row(CFG_BLIT_WIDTH, 10'd0));
        plan.push_back(reg_row(CFG_BLIT_HEIGHT, 10'd0));
        plan.push_back(pix_fixed(8'h80, 2'd2, bank_sel(4'd5, 1'b0),
                                 px_write(4'd5, 16'h017F, 8'h80)));
        plan.push_back(pix_fixed(8'h7F, 2'd1, px_write(4'd5, 16'h017F, 8'h7F), NO_RESULT));
        plan.push_back(reg_row(CFG_DEST_X, 10'd252));
        plan.push_back(reg_row(CFG_DEST_Y, 10'd102));
        plan.push_back(reg_row(CFG_BLIT_WIDTH, 10'd6));
        plan.push_back(reg_row(CFG_BLIT_HEIGHT, 10'd2));
        plan.push_back(reg_row(CFG_KEY_ENABLE, 10'h001));
        plan.push_back(pix_row(8'h11));
        plan.push_back(pix_row(8'h22));
        plan.push_back(pix_row(8'h33));
        plan.push_back(pix_row(8'h44));
        plan.push_back(pix_row(8'h55));
        plan.push_back(pix_row(8'h66));
        plan.push_back(pix_row(8'h77));
        plan.push_back(pix_row(8'h88));
        plan.push_back(pix_row(8'h99));
        plan.push_back(pix_row(8'hAA));
        plan.push_back(pix_row(8'h5A));
        plan.push_back(pix_row(8'hBB));
        plan.push_back(pix_row(8'hCC));

        foreach (plan[k]) run_step(plan[k]);

        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                dx = $urandom_range(0, 1) ? 0 : ($urandom_range(0, 1) ? 639 : 1023);
                dy = $urandom_range(0, 1) ? 0 : ($urandom_range(0, 1) ? 479 : 511);
                w  = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                          : ($urandom_range(0, 1) ? 640 : 1023);
                h  = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                          : ($urandom_range(0, 1) ? 480 : 511);
            end else if (shape < 7) begin
                // straddle a bank boundary, within a row or between rows
                kbank = $urandom_range(1, 4);
                brow  = (BANK_BYTES * kbank) / SCREEN_WIDTH;
                bcol  = BANK_BYTES * kbank - SCREEN_WIDTH * brow;
                w     = $urandom_range(1, 16);
                h     = $urandom_range(1, 6);
                dy    = brow - $urandom_range(0, h - 1);
                dx    = $urandom_range(0, 1) ? bcol - $urandom_range(0, w - 1)
                                             : $urandom_range(0, 639);
            end else begin
                dx = $urandom_range(0, 1023);
                dy = $urandom_range(0, 511);
                w  = $urandom_range(0, 1023);
                h  = $urandom_range(0, 511);
            end
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
                run_step(reg_row(CFG_DEST_X, 10'(dx)));
                run_step(reg_row(CFG_DEST_Y, 10'(dy)));
                run_step(reg_row(CFG_BLIT_WIDTH, 10'(w)));
                run_step(reg_row(CFG_BLIT_HEIGHT, 10'(h)));
            end
            key_val    = 10'($urandom_range(0, 1023));
            key_on_val = 10'($urandom_range(0, 1023));
            if (phase == PRESSURE_PHASE) key_on_val[0] = 1'b0;
            run_step(reg_row(CFG_KEY_COLOR, key_val));
            run_step(reg_row(CFG_KEY_ENABLE, key_on_val));
            if ($urandom_range(0, 7) == 0) begin
                run_step(reg_row($urandom_range(0, 1) ? CFG_IDX_SPARE : CFG_IDX_TOP,
                                 10'($urandom)));
            end
            n_items = (phase == PRESSURE_PHASE) ? 48 : $urandom_range(4, 40);
            if (phase == PRESSURE_PHASE) hold_req = 1'b1;
            repeat (n_items) begin
                p = (key_on_val[0] && $urandom_range(0, 3) == 0) ? key_val[7:0]
                                                                 : 8'($urandom_range(0, 255));
                run_step(pix_row(p));
                random_sent++;
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (fb_ops_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** banked_color_keyed_blit: PASSED **");
        end else begin
            $display("** banked_color_keyed_blit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- banked_color_keyed_blit.f -----
rtl/core/bckb_pkg.sv
rtl/core/bckb_front.sv
rtl/core/bckb_emit.sv
rtl/core/bckb_queue.sv
rtl/core/banked_color_keyed_blit.sv
verif/tb_banked_color_keyed_blit.sv
